>>> rtl/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared types and constants for the rounded square root / 3/4-power block.
// ----------------------------------------------------------------------------
package rsq_pkg;

  // Default number of input bits used
  localparam int unsigned VALUE_WIDTH_DEF = 31;

  // Fixed result field widths
  localparam int unsigned ROOT_OUT_W  = 16;
  localparam int unsigned POWER_OUT_W = 24;

  // Top-level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_QROOT,
    ST_MUL
  } rsq_state_e;

endpackage : rsq_pkg

>>> rtl/rsq_root.sv
// ----------------------------------------------------------------------------
// rsq_root
// Bit-serial restoring square root, one root bit per cycle, with
// round-to-nearest on the final root (zero radicand gives 1).
// ----------------------------------------------------------------------------
module rsq_root #(
  parameter int unsigned RW = 16,
  parameter int unsigned CW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*RW-1:0] radicand_i,
  input  logic [CW-1:0]   steps_i,
  output logic            done_o,
  output logic [RW:0]     rounded_o
);

  localparam int unsigned RADW = 2 * RW;
  localparam int unsigned RMW  = RW + 2;

  logic [RADW-1:0] rad_q, rad_d;
  logic [RMW-1:0]  rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;

  logic [RMW-1:0]  rem_sh;
  logic [RMW-1:0]  sub_val;
  logic [RMW:0]    trial;
  logic            neg;
  logic            round_up;

  // One restoring step: bring down the next bit pair, try subtract
  assign rem_sh  = {rem_q[RMW-3:0], rad_q[RADW-1 -: 2]};
  assign sub_val = {root_q, 2'b01};
  assign trial   = {1'b0, rem_sh} - {1'b0, sub_val};
  assign neg     = trial[RMW];

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = steps_i;
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d  = {rad_q[RADW-3:0], 2'b00};
      root_d = {root_q[RW-2:0], ~neg};
      rem_d  = neg ? rem_sh : trial[RMW-1:0];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // Round to nearest: remainder above the floor root means round up
  assign round_up  = rem_q > {2'b00, root_q};
  assign rounded_o = (root_q == '0) ? (RW+1)'(1)
                                    : ({1'b0, root_q} + {{RW{1'b0}}, round_up});
  assign done_o    = done_q;

endmodule : rsq_root

>>> rtl/rounded_sqrt_three_quarter_power.sv
// ----------------------------------------------------------------------------
// rounded_sqrt_three_quarter_power
// Sequence from accepted start to done_o: RW = ceil(VALUE_WIDTH/2) root steps,
//   then Q root steps on the rounded root, then Q+1 shift-add multiply
//   steps; the root steps run on the bit-serial root unit.
// One transfer at a time; a new start is taken only while idle, also in the strobe
//   cycle. Results cannot be stalled. Async active-low reset returns to idle.
// ----------------------------------------------------------------------------
module rounded_sqrt_three_quarter_power #(
  parameter int unsigned VALUE_WIDTH = rsq_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [VALUE_WIDTH-1:0]         window_value_i,
  output logic                           done_o,
  output logic [rsq_pkg::ROOT_OUT_W-1:0]  root_rounded_o,
  output logic [rsq_pkg::POWER_OUT_W-1:0] three_quarter_power_o
);

  import rsq_pkg::*;

  localparam int unsigned RW     = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned RADW   = 2 * RW;
  localparam int unsigned Q      = (RW + 2) / 2;
  localparam int unsigned CW     = $clog2(RW + 1);
  localparam int unsigned PROD_W = RW + Q + 2;
  localparam int unsigned MCW    = $clog2(Q + 2);
  localparam int unsigned QSH    = RADW - 2 * Q;

  rsq_state_e state_q, state_d;

  logic [RW:0]       r_q;
  logic [Q:0]        mplier_q;
  logic [PROD_W-1:0] mcand_q;
  logic [PROD_W-1:0] acc_q;
  logic [MCW-1:0]    mcnt_q;
  logic              done_q;

  logic              unit_start;
  logic [RADW-1:0]   unit_rad;
  logic [CW-1:0]     unit_steps;
  logic              unit_done;
  logic [RW:0]       unit_rounded;
  logic              accept;
  logic              mul_last;
  logic [RADW-1:0]   rad1;
  logic [RADW-1:0]   rad2;

  logic [ROOT_OUT_W+RW:0]      root_ext;
  logic [POWER_OUT_W+PROD_W-1:0] power_ext;

  assign accept   = start && (state_q == ST_IDLE);
  assign mul_last = (state_q == ST_MUL) && (mcnt_q == MCW'(1));

  // Radicands: input zero-extended for full pass, fresh rounded root taken
  // straight from the unit for the short pass
  assign rad1 = {{(RADW-VALUE_WIDTH){1'b0}}, window_value_i};
  assign rad2 = {{(RADW-RW-1){1'b0}}, unit_rounded} << QSH;

  // Shared bit-serial root unit
  rsq_root #(
    .RW (RW),
    .CW (CW)
  ) u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .radicand_i (unit_rad),
    .steps_i    (unit_steps),
    .done_o     (unit_done),
    .rounded_o  (unit_rounded)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_ROOT;
      ST_ROOT:  if (unit_done) state_d = ST_QROOT;
      ST_QROOT: if (unit_done) state_d = ST_MUL;
      ST_MUL:   if (mul_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    unit_start = 1'b0;
    unit_rad   = rad1;
    unit_steps = CW'(RW);
    busy       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        unit_start = start;
      end
      ST_ROOT: begin
        unit_start = unit_done;
        unit_rad   = rad2;
        unit_steps = CW'(Q);
      end
      ST_QROOT: begin
        unit_rad   = rad2;
        unit_steps = CW'(Q);
      end
      ST_MUL: begin
        unit_rad   = rad2;
      end
      default: begin
        busy       = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= mul_last;
      if (state_q == ST_QROOT && unit_done) begin
        mcnt_q <= MCW'(Q + 1);
      end else if (state_q == ST_MUL) begin
        mcnt_q <= mcnt_q - MCW'(1);
      end
    end
  end

  // Root capture and shift-add multiply r * q
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROOT && unit_done) begin
      r_q <= unit_rounded;
    end
    if (state_q == ST_QROOT && unit_done) begin
      mplier_q <= unit_rounded[Q:0];
      mcand_q  <= {{(PROD_W-RW-1){1'b0}}, r_q};
      acc_q    <= '0;
    end else if (state_q == ST_MUL) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[Q:1]};
    end
  end

  // Result ports: low bits of each value
  assign root_ext  = {{ROOT_OUT_W{1'b0}}, r_q};
  assign power_ext = {{POWER_OUT_W{1'b0}}, acc_q};

  assign root_rounded_o        = root_ext[ROOT_OUT_W-1:0];
  assign three_quarter_power_o = power_ext[POWER_OUT_W-1:0];
  assign done_o                = done_q;

`ifndef SYNTHESIS
  // Root unit only finishes while the sequencer waits on it
  a_unit_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> (state_q == ST_ROOT || state_q == ST_QROOT))
    else $error("root unit done outside a root state");

  // Strobe follows the last multiply step
  a_done_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_MUL && state_q == ST_IDLE)
    else $error("result strobe without multiply completion");

  // Rounded root is never zero on a transfer
  a_root_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> r_q != '0)
    else $error("zero root delivered");

  // Accepted start keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("not busy after accepted start");
`endif

endmodule : rounded_sqrt_three_quarter_power

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives window values into the rounded square root / 3/4-power unit in bursts
// with random gaps, predicts each result in the testbench, and checks every
// strobed result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW       = rsq_pkg::VALUE_WIDTH_DEF;
  localparam int unsigned ROOT_W   = rsq_pkg::ROOT_OUT_W;
  localparam int unsigned POWER_W  = rsq_pkg::POWER_OUT_W;
  localparam longint unsigned VMAX = (64'd1 << VW) - 1;
  localparam int unsigned N_RANDOM = 1250;

  // One window update waiting to be sent
  typedef struct {
    logic [VW-1:0] value;
    bit            drain;  // hold off until all results are back
  } window_item_t;

  // Predicted root and 3/4 power for one transfer
  typedef struct {
    logic [ROOT_W-1:0]  root;
    logic [POWER_W-1:0] power;
  } root_pair_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [VW-1:0]      window_value = '0;
  logic               done;
  logic [ROOT_W-1:0]  root_rounded;
  logic [POWER_W-1:0] three_quarter_power;

  window_item_t window_q[$];
  root_pair_t   roots_due_q[$];
  logic         granted = 1'b0;
  int unsigned  error_count = 0;
  int unsigned  burst_left = 1;
  int unsigned  gap_left = 0;

  rounded_sqrt_three_quarter_power i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .window_value_i        (window_value),
    .done_o                (done),
    .root_rounded_o        (root_rounded),
    .three_quarter_power_o (three_quarter_power)
  );

  always #5 clk_i = ~clk_i;

  // Square root rounded to nearest; zero maps to one
  function automatic longint unsigned round_isqrt(input longint unsigned v);
    longint unsigned s;
    longint unsigned trial;
    s = 0;
    if (v == 0) return 1;
    for (int b = 31; b >= 0; b--) begin
      trial = s | (64'd1 << b);
      if (trial * trial <= v) s = trial;
    end
    // no ties: 2v is even, s^2 + (s+1)^2 is odd
    if (v > s * s + s) s = s + 1;
    return s;
  endfunction

  function automatic root_pair_t predict_roots(input logic [VW-1:0] x);
    root_pair_t      res;
    longint unsigned r;
    longint unsigned q;
    longint unsigned p;
    r = round_isqrt(longint'(x));
    q = round_isqrt(r);
    p = r * q;
    res.root  = r[ROOT_W-1:0];
    res.power = p[POWER_W-1:0];
    return res;
  endfunction

  task automatic queue_window(input longint unsigned v, input bit drain);
    window_item_t item;
    item.value = v[VW-1:0];
    item.drain = drain;
    window_q.push_back(item);
  endtask

  // Sender: bursts of transfers, random gaps, start held until taken
  always @(negedge clk_i) begin
    window_item_t item;
    logic         next_start;
    next_start = 1'b0;
    if (rst_ni && !(start && !granted)) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (window_q.size() > 0 &&
                   !(window_q[0].drain && roots_due_q.size() > 0)) begin
        item = window_q.pop_front();
        window_value <= item.value;
        next_start = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      start <= next_start;
    end
  end

  // Monitor: check strobed results, then record newly accepted transfers
  always @(posedge clk_i) begin
    root_pair_t want;
    if (rst_ni) begin
      if (done) begin
        if (roots_due_q.size() == 0) begin
          $error("result strobe with no transfer outstanding: root %0d power %0d",
                 root_rounded, three_quarter_power);
          error_count++;
        end else begin
          want = roots_due_q.pop_front();
          if (root_rounded !== want.root) begin
            $error("root_rounded: expected %0d, got %0d", want.root, root_rounded);
            error_count++;
          end
          if (three_quarter_power !== want.power) begin
            $error("three_quarter_power: expected %0d, got %0d",
                   want.power, three_quarter_power);
            error_count++;
          end
        end
      end
      if (start && !busy) roots_due_q.push_back(predict_roots(window_value));
      granted <= start && !busy;
    end else begin
      granted <= 1'b0;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    longint unsigned s;
    longint unsigned v;
    int unsigned     kind;

    // zero quirk, small values, rounding boundaries, top of range
    queue_window(0, 1'b0);
    queue_window(1, 1'b0);
    queue_window(2, 1'b0);
    queue_window(3, 1'b0);
    queue_window(4, 1'b0);
    queue_window(6, 1'b0);
    queue_window(7, 1'b0);
    queue_window(9, 1'b0);
    queue_window(15, 1'b0);
    queue_window(16, 1'b0);
    queue_window(64'd46340 * 46340 - 1, 1'b0);
    queue_window(64'd46340 * 46340, 1'b0);
    queue_window(64'd46340 * 46340 + 46340, 1'b0);
    queue_window(64'd46340 * 46340 + 46341, 1'b0);
    queue_window(VMAX, 1'b0);
    queue_window(64'h5555_5555 & VMAX, 1'b0);
    queue_window(64'h2AAA_AAAA & VMAX, 1'b0);
    queue_window(64'd1 << (VW - 1), 1'b0);
    queue_window((64'd1 << (VW - 1)) - 1, 1'b0);
    queue_window(0, 1'b1);

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        v = $urandom;
      end else if (kind < 5) begin
        v = $urandom >> $urandom_range(1, 31);
      end else if (kind < 6) begin
        v = $urandom_range(0, 1000);
      end else begin
        // just around a perfect square or a rounding boundary
        s = $urandom_range(1, 46340);
        case ($urandom_range(0, 3))
          0: v = s * s - 1;
          1: v = s * s;
          2: v = s * s + s;
          default: v = s * s + s + 1;
        endcase
      end
      if (v > VMAX) v = VMAX;
      queue_window(v, (n % 300) == 150);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (window_q.size() > 0 || start) @(posedge clk_i);
    while (roots_due_q.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (error_count == 0) begin
      $display("rounded_sqrt_three_quarter_power: match");
    end else begin
      $display("rounded_sqrt_three_quarter_power: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("rounded_sqrt_three_quarter_power: mismatch");
    $finish;
  end

endmodule : testbench
